@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication on the rising edge of clock, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication on the rising edge of clock, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/rqs_pkg.sv @@
`timescale 1ns / 1ps
package rqs_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;

   localparam logic [1:0] CMD_PUSH         = 2'd0;
   localparam logic [1:0] CMD_POP_OLDEST   = 2'd1;
   localparam logic [1:0] CMD_POP_SHORTEST = 2'd2;
   localparam logic [1:0] CMD_POP_URGENT   = 2'd3;

   localparam logic [1:0] STAT_PUSHED = 2'd0;
   localparam logic [1:0] STAT_POPPED = 2'd1;
   localparam logic [1:0] STAT_EMPTY  = 2'd2;
   localparam logic [1:0] STAT_FULL   = 2'd3;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [15:0] burst;
   } entry_type;

   typedef struct packed {
      logic take_next;
      logic take_head;
      logic take_push;
   } cell_ctl_type;

endpackage

@@ rtl/rqs_cell.sv @@
`timescale 1ns / 1ps
module rqs_cell (
   input  logic                  clock,
   input  rqs_pkg::cell_ctl_type ctl,
   input  rqs_pkg::entry_type    next_ent,
   input  rqs_pkg::entry_type    head_ent,
   input  rqs_pkg::entry_type    push_ent,
   output rqs_pkg::entry_type    ent
);
   import rqs_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;

   always_comb begin
      priority if (ctl.take_push) begin
         ent_in = push_ent;
      end else if (ctl.take_head) begin
         ent_in = head_ent;
      end else if (ctl.take_next) begin
         ent_in = next_ent;
      end else begin
         ent_in = ent_ff;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

@@ rtl/rqs_scan.sv @@
`timescale 1ns / 1ps
module rqs_scan #(
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               en,
   input  logic               first,
   input  logic [1:0]         mode,
   input  rqs_pkg::entry_type head,
   input  logic [IDX_W-1:0]   idx,
   output logic [IDX_W-1:0]   best_idx,
   output rqs_pkg::entry_type best_ent
);
   import rqs_pkg::*;

   logic [IDX_W-1:0] best_idx_ff;
   entry_type        best_ent_ff;
   logic             take;

   // Later entries win ties, so compare inclusively.
   always_comb begin
      unique case (mode)
         CMD_POP_SHORTEST: take = first || (head.burst <= best_ent_ff.burst);
         CMD_POP_URGENT:   take = first || (head.prio >= best_ent_ff.prio);
         default:          take = first;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en && take) begin
         best_idx_ff <= idx;
         best_ent_ff <= head;
      end
   end

   assign best_idx = best_idx_ff;
   assign best_ent = best_ent_ff;

endmodule

@@ rtl/process_ready_queue_selector_unit.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Ready queue of up to QUEUE_DEPTH process entries held in a row of cells,
// oldest in cell 0. A push, or any command on an empty queue, answers on
// rsp_strobe in the cycle after start is taken. A pop rotates the occupied
// cells once around the row while a comparator watches cell 0, then closes
// the gap in the S_CMP state; the answer is registered from there, and busy
// stays high until it shows. Results come as a one-cycle strobe and must be
// taken when shown; the receiver cannot stall.
module process_ready_queue_selector_unit #(
   parameter int QUEUE_DEPTH = rqs_pkg::DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_proc_id,
   input  logic [7:0]  req_prio,
   input  logic [15:0] req_burst_len,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_id,
   output logic [7:0]  rsp_out_prio,
   output logic [15:0] rsp_out_burst
);
   import rqs_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ROT  = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic             strobe_ff, strobe_in;
   logic [1:0]       status_ff, status_in;
   entry_type        out_ff, out_in;

   logic             do_load, do_rot, do_cmp;
   logic [CNT_W-1:0] last_cnt;
   entry_type        push_ent;
   entry_type        cells [QUEUE_DEPTH];
   cell_ctl_type     ctls [QUEUE_DEPTH];
   logic [IDX_W-1:0] best_idx;
   entry_type        best_ent;

   assign push_ent = '{id: req_proc_id, prio: req_prio, burst: req_burst_len};
   assign last_cnt = count_ff - CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      cmd_in    = cmd_ff;
      strobe_in = 1'b0;
      status_in = STAT_PUSHED;
      out_in    = '0;
      do_load   = 1'b0;
      do_rot    = 1'b0;
      do_cmp    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_PUSH) begin
                  strobe_in = 1'b1;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = STAT_FULL;
                  end else begin
                     do_load  = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = STAT_EMPTY;
               end else begin
                  cmd_in   = req_cmd;
                  step_in  = '0;
                  state_in = S_ROT;
               end
            end
         end
         S_ROT: begin
            do_rot  = 1'b1;
            step_in = step_ff + IDX_W'(1);
            // Full turn done: the row is back in arrival order.
            if (step_ff == last_cnt[IDX_W-1:0]) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            do_cmp    = 1'b1;
            count_in  = last_cnt;
            strobe_in = 1'b1;
            status_in = STAT_POPPED;
            out_in    = best_ent;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      localparam logic [CNT_W-1:0] KC = CNT_W'(k);
      localparam logic [CNT_W-1:0] KN = CNT_W'(k + 1);
      entry_type next_ent;

      if (k == QUEUE_DEPTH - 1) begin : g_last
         assign next_ent = cells[k];
      end else begin : g_mid
         assign next_ent = cells[k + 1];
      end

      // The head wraps into the youngest occupied cell; compaction shifts at and past the gap.
      assign ctls[k].take_push = do_load && (count_ff == KC);
      assign ctls[k].take_head = do_rot && (count_ff == KN);
      assign ctls[k].take_next = (do_rot && (count_ff != KN))
                               || (do_cmp && (KC >= CNT_W'(best_idx)));

      rqs_cell u_cell (
         .clock    (clock),
         .ctl      (ctls[k]),
         .next_ent (next_ent),
         .head_ent (cells[0]),
         .push_ent (push_ent),
         .ent      (cells[k])
      );
   end

   rqs_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock    (clock),
      .en       (do_rot),
      .first    (step_ff == '0),
      .mode     (cmd_ff),
      .head     (cells[0]),
      .idx      (step_ff),
      .best_idx (best_idx),
      .best_ent (best_ent)
   );

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_id    = out_ff.id;
   assign rsp_out_prio  = out_ff.prio;
   assign rsp_out_burst = out_ff.burst;

   `ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_IMPL(a_strobe_idle, strobe_ff, state_ff == S_IDLE)
   `ASSERT_IMPL(a_pop_shrinks, strobe_ff && (status_ff == STAT_POPPED),
      count_ff == $past(count_ff) - CNT_W'(1))
   `ASSERT_NEXT(a_rot_busy, state_ff == S_ROT, busy && !strobe_ff)

endmodule

@@ dv/tb_process_ready_queue_selector_unit.sv @@
`timescale 1ns / 1ps
module tb_process_ready_queue_selector_unit;
   import rqs_pkg::*;

   localparam int DEPTH        = DEF_QUEUE_DEPTH;
   localparam int RANDOM_ITEMS = 1527;
   localparam int MAX_PRINTS   = 200;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] id;
      logic [7:0]  prio;
      logic [15:0] burst;
   } answer_type;

   class selector_scoreboard;
      entry_type  shadow_queue[$];
      answer_type expected_answers[$];
      int         error_count;

      function int pending();
         return expected_answers.size();
      endfunction

      task report_mismatch(input string what, input logic [15:0] seen,
                           input logic [15:0] want);
         error_count++;
         if (error_count <= MAX_PRINTS)
            $display("%0t mismatch: %s seen %h expected %h", $realtime, what, seen, want);
      endtask

      // Work out the answer to one accepted transaction and advance the queue.
      function void note_input(input logic [1:0] c, input logic [15:0] pid,
                               input logic [7:0] pr, input logic [15:0] bl);
         answer_type ans;
         entry_type  ent;
         int         pos;
         int         k;
         ans = '0;
         if (c == CMD_PUSH) begin
            if (shadow_queue.size() >= DEPTH) begin
               ans.status = STAT_FULL;
            end else begin
               ent.id    = pid;
               ent.prio  = pr;
               ent.burst = bl;
               shadow_queue.push_back(ent);
               ans.status = STAT_PUSHED;
            end
         end else if (shadow_queue.size() == 0) begin
            ans.status = STAT_EMPTY;
         end else begin
            pos = 0;
            // Ties go to the latest arrival, hence the non-strict compares.
            for (k = 1; k < shadow_queue.size(); k++) begin
               if (c == CMD_POP_SHORTEST && shadow_queue[k].burst <= shadow_queue[pos].burst)
                  pos = k;
               if (c == CMD_POP_URGENT && shadow_queue[k].prio >= shadow_queue[pos].prio)
                  pos = k;
            end
            ans.status = STAT_POPPED;
            ans.id     = shadow_queue[pos].id;
            ans.prio   = shadow_queue[pos].prio;
            ans.burst  = shadow_queue[pos].burst;
            shadow_queue.delete(pos);
         end
         expected_answers.push_back(ans);
      endfunction

      task check_result(input logic [1:0] st, input logic [15:0] oid,
                        input logic [7:0] opr, input logic [15:0] obu);
         answer_type want;
         if (expected_answers.size() == 0) begin
            report_mismatch("result with no transaction pending, status", 16'(st), 16'h0);
         end else begin
            want = expected_answers.pop_front();
            if (st !== want.status)
               report_mismatch("status", 16'(st), 16'(want.status));
            if (oid !== want.id)
               report_mismatch("out_id", oid, want.id);
            if (opr !== want.prio)
               report_mismatch("out_prio", 16'(opr), 16'(want.prio));
            if (obu !== want.burst)
               report_mismatch("out_burst", obu, want.burst);
         end
      endtask

      task flush_leftovers();
         answer_type want;
         while (expected_answers.size() != 0) begin
            want = expected_answers.pop_front();
            report_mismatch("missing result, status", 16'h0, 16'(want.status));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [15:0] req_proc_id;
   logic [7:0]  req_prio;
   logic [15:0] req_burst_len;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_id;
   logic [7:0]  rsp_out_prio;
   logic [15:0] rsp_out_burst;

   selector_scoreboard sb;

   process_ready_queue_selector_unit #(
      .QUEUE_DEPTH(DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_proc_id   (req_proc_id),
      .req_prio      (req_prio),
      .req_burst_len (req_burst_len),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_out_id    (rsp_out_id),
      .rsp_out_prio  (rsp_out_prio),
      .rsp_out_burst (rsp_out_burst)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_status, rsp_out_id, rsp_out_prio, rsp_out_burst);
   end

   // Called at a falling edge; returns at the falling edge after the transaction is taken.
   task automatic send_item(input logic [1:0] c, input logic [15:0] pid,
                            input logic [7:0] pr, input logic [15:0] bl);
      req_cmd       = c;
      req_proc_id   = pid;
      req_prio      = pr;
      req_burst_len = bl;
      start         = 1'b1;
      do @(posedge clock); while (busy);
      sb.note_input(c, pid, pr, bl);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Bias toward small values and extremes so ties and edge values show up often.
   function automatic logic [15:0] pick_field();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 3));
         1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int         i;
      int         burst_left;
      int         push_pct;
      logic [1:0] c;

      sb            = new();
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_cmd       = CMD_PUSH;
      req_proc_id   = '0;
      req_prio      = '0;
      req_burst_len = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Pops on an empty queue, then fill with tied priorities and bursts.
      send_item(CMD_POP_OLDEST, 16'hFFFF, 8'hFF, 16'hFFFF);
      send_item(CMD_POP_SHORTEST, 16'h0000, 8'h00, 16'h0000);
      send_item(CMD_POP_URGENT, 16'h5A5A, 8'hA5, 16'hA5A5);
      for (i = 0; i < DEPTH; i++)
         send_item(CMD_PUSH, (i == DEPTH - 1) ? 16'hFFFF : 16'(i * 16'h0111),
                   (i % 4 == 1) ? 8'hFF : 8'(i),
                   (i % 5 == 2) ? 16'h0000 : 16'(16'hFFFF - i));
      send_item(CMD_PUSH, 16'hABCD, 8'h55, 16'h1234);
      send_item(CMD_POP_URGENT, 16'h0, 8'h0, 16'h0);
      send_item(CMD_POP_SHORTEST, 16'h0, 8'h0, 16'h0);
      send_item(CMD_POP_OLDEST, 16'h0, 8'h0, 16'h0);
      wait_drained();

      burst_left = 0;
      push_pct   = 50;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: push_pct = 25;
               1: push_pct = 50;
               2: push_pct = 75;
               default: push_pct = 90;
            endcase
         end
         if (i % 500 == 499)
            wait_drained();
         if (burst_left == 0) begin
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
         end
         burst_left--;
         if ($urandom_range(1, 100) <= push_pct)
            c = CMD_PUSH;
         else
            c = 2'($urandom_range(CMD_POP_OLDEST, CMD_POP_URGENT));
         send_item(c, 16'($urandom), 8'(pick_field()), pick_field());
      end

      wait_drained();
      repeat (DEPTH + 4) @(negedge clock);
      sb.flush_leftovers();
      if (sb.error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rqs_pkg.sv
rtl/rqs_cell.sv
rtl/rqs_scan.sv
rtl/process_ready_queue_selector_unit.sv
dv/tb_process_ready_queue_selector_unit.sv
